/* hw/rtl/wsfp_pkg.sv */
// shared types and constants for the websocket frame parser
package wsfp_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  localparam int unsigned LenW = 63;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] BYTES_LEN_16 = 4'd2;
  localparam logic [3:0] BYTES_LEN_64 = 4'd8;
  localparam logic [3:0] BYTES_KEY    = 4'd4;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic              fin;
    logic [2:0]        rsv;
    logic [3:0]        opcode;
    logic              mask;
    logic [LenW-1:0]   len;
    logic              last;
  } res_t;

  function automatic logic opcode_known(logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

/* hw/rtl/wsfp_parse.sv */
// parser state and per-byte decode of header, key and payload
module wsfp_parse
  import wsfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e            phase_q, phase_d;
  logic [7:0]        fhb_q, fhb_d;
  logic              mask_q, mask_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [31:0]       key_q, key_d;
  logic [LenW-1:0]   rcnt_q, rcnt_d;

  logic [6:0]        code;
  logic [3:0]        cnt_dec;
  logic [LenW-1:0]   len_shift;
  logic [LenW-1:0]   rcnt_inc;
  logic              pay_last;
  logic [7:0]        key_byte;
  logic [LenW-1:0]   hdr_len;

  // shared decode terms
  always_comb begin
    code      = byte_i[6:0];
    cnt_dec   = cnt_q - 4'd1;
    len_shift = {len_q[LenW-9:0], byte_i};
    rcnt_inc  = rcnt_q + {{(LenW-1){1'b0}}, 1'b1};
    pay_last  = (rcnt_inc >= len_q);
    unique case (rcnt_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    unique case (phase_q)
      PH_SECOND: hdr_len = {{(LenW-7){1'b0}}, code};
      PH_EXTLEN: hdr_len = len_shift;
      default:   hdr_len = len_q;
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_SECOND: begin
        if ((code == LEN_CODE_16) || (code == LEN_CODE_64)) begin
          phase_d = PH_EXTLEN;
        end else if (byte_i[7]) begin
          phase_d = PH_KEY;
        end else begin
          phase_d = (hdr_len == '0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_EXTLEN: begin
        if (cnt_dec != 4'd0) begin
          phase_d = PH_EXTLEN;
        end else if (mask_q) begin
          phase_d = PH_KEY;
        end else begin
          phase_d = (hdr_len == '0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_KEY: begin
        if (cnt_dec != 4'd0) begin
          phase_d = PH_KEY;
        end else begin
          phase_d = (hdr_len == '0) ? PH_FIRST : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        phase_d = pay_last ? PH_FIRST : PH_PAYLOAD;
      end
      default: begin
        phase_d = opcode_known(byte_i[3:0]) ? PH_SECOND : PH_FIRST;
      end
    endcase
  end

  // datapath updates and result
  always_comb begin
    fhb_d  = fhb_q;
    mask_d = mask_q;
    cnt_d  = cnt_q;
    len_d  = len_q;
    key_d  = key_q;
    rcnt_d = rcnt_q;

    res_valid_o     = 1'b0;
    res_o.kind      = KIND_HEADER;
    res_o.data_byte = 8'd0;
    res_o.fin       = fhb_q[7];
    res_o.rsv       = fhb_q[6:4];
    res_o.opcode    = fhb_q[3:0];
    res_o.mask      = mask_q;
    res_o.len       = hdr_len;
    res_o.last      = (hdr_len == '0);

    unique case (phase_q)
      PH_SECOND: begin
        mask_d = byte_i[7];
        res_o.mask = byte_i[7];
        if (code == LEN_CODE_16) begin
          len_d = '0;
          cnt_d = BYTES_LEN_16;
        end else if (code == LEN_CODE_64) begin
          len_d = '0;
          cnt_d = BYTES_LEN_64;
        end else begin
          len_d = hdr_len;
          if (byte_i[7]) begin
            cnt_d = BYTES_KEY;
          end else begin
            rcnt_d      = '0;
            res_valid_o = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        len_d = len_shift;
        cnt_d = cnt_dec;
        if (cnt_dec == 4'd0) begin
          if (mask_q) begin
            cnt_d = BYTES_KEY;
          end else begin
            rcnt_d      = '0;
            res_valid_o = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], byte_i};
        cnt_d = cnt_dec;
        if (cnt_dec == 4'd0) begin
          rcnt_d      = '0;
          res_valid_o = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        rcnt_d          = rcnt_inc;
        res_valid_o     = 1'b1;
        res_o.kind      = KIND_PAYLOAD;
        res_o.data_byte = mask_q ? (byte_i ^ key_byte) : byte_i;
        res_o.len       = len_q;
        res_o.last      = pay_last;
      end
      default: begin
        fhb_d = byte_i;
        if (!opcode_known(byte_i[3:0])) begin
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_ERROR;
          res_o.fin    = byte_i[7];
          res_o.rsv    = byte_i[6:4];
          res_o.opcode = byte_i[3:0];
          res_o.mask   = 1'b0;
          res_o.len    = '0;
          res_o.last   = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      fhb_q   <= 8'd0;
      mask_q  <= 1'b0;
      cnt_q   <= 4'd0;
      len_q   <= '0;
      key_q   <= 32'd0;
      rcnt_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fhb_q   <= fhb_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      key_q   <= key_d;
      rcnt_q  <= rcnt_d;
    end
  end

  a_payload_in_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && (res_o.kind == KIND_PAYLOAD)) |-> (phase_q == PH_PAYLOAD))
    else $error("payload result outside payload phase");

  a_error_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && (res_o.kind == KIND_ERROR)) |=> (phase_q == PH_FIRST))
    else $error("error result did not return to header wait");

  a_key_done_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_KEY) && (cnt_q == 4'd1)) |-> res_valid_o)
    else $error("last key byte gave no header result");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && (res_o.kind == KIND_PAYLOAD) && res_o.last)
      |=> (phase_q == PH_FIRST))
    else $error("frame end did not return to header wait");

endmodule

/* hw/rtl/websocket_frame_parser.sv */
// top level: input register, frame parser and result register
// Takes one byte of a WebSocket stream per cycle and sustains one byte per cycle when
// the result side does not stall. An accepted byte waits in the input register while
// the parser decodes it against its running state (phase, first header byte, extended
// length, masking key, payload count), and any result is written to the output register
// when the parser steps. The single parser stage sets the rate; a held result stalls the
// input register, which stalls the input side.
module websocket_frame_parser
  import wsfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          stream_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          data_byte_o,
  output logic                final_flag_o,
  output logic [2:0]          reserved_bits_o,
  output logic [3:0]          frame_opcode_o,
  output logic                mask_flag_o,
  output logic [LenW-1:0]     frame_length_o,
  output logic                frame_end_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  res_t       out_q;

  logic       advance;
  logic       step;
  logic       res_valid;
  res_t       res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  wsfp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= stream_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign data_byte_o     = out_q.data_byte;
  assign final_flag_o    = out_q.fin;
  assign reserved_bits_o = out_q.rsv;
  assign frame_opcode_o  = out_q.opcode;
  assign mask_flag_o     = out_q.mask;
  assign frame_length_o  = out_q.len;
  assign frame_end_o     = out_q.last;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result was dropped");

  a_step_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (!out_valid_q || !out_stall_i))
    else $error("parser advanced while result held");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_valid) |=> out_valid_q)
    else $error("parser result not registered");

endmodule
